// ===== hw/rtl/tmcw_pkg.sv =====
// tmcw_pkg: shared constants, codes and types of the text-mode console writer.
// Used by the front end, the back end and the top level; depends on nothing.
package tmcw_pkg;

	// Default screen geometry
	localparam int DEF_COLUMNS = 80;
	localparam int DEF_ROWS    = 25;

	// Depth of the command queue between front and back
	localparam int DEF_QUEUE_DEPTH = 4;

	// Cell layout: attribute byte over character byte
	localparam int CELL_W  = 16;
	localparam int ATTR_W  = 8;
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 4;

	localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'd32;
	localparam logic [COLOR_W-1:0] FG_RESET     = 4'd7;
	localparam logic [COLOR_W-1:0] BG_RESET     = 4'd0;

	// Request codes
	typedef enum logic [1:0] {
		REQ_WRITE  = 2'd0,
		REQ_CLEAR  = 2'd1,
		REQ_SCROLL = 2'd2,
		REQ_READ   = 2'd3
	} req_type_t;

	// Configuration register index (byte address bit 2)
	typedef enum logic [0:0] {
		REG_FG = 1'b0,
		REG_BG = 1'b1
	} cfg_reg_t;

	// Back-end sequencer states
	typedef enum logic [1:0] {
		ST_IDLE  = 2'd0,
		ST_SWEEP = 2'd1,
		ST_DRAIN = 2'd2
	} back_state_t;

	// Width of one queued command for a given geometry:
	// wr_en, rd_en, sweep, addr, data, offset, col, row
	function automatic int entry_width(input int cols, input int rows);
		return 3 + $clog2(cols * rows) + CELL_W + ($clog2(cols * rows) + 1)
			+ $clog2(cols) + $clog2(rows);
	endfunction

endpackage

// ===== hw/rtl/tmcw_ram.sv =====
// tmcw_ram: generic simple dual-port RAM, one write and one registered read port.
// Self-contained; no package needed.
module tmcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hw/rtl/tmcw_queue.sv =====
// tmcw_queue: small register FIFO carrying commands from front to back.
// Self-contained; no package needed.
module tmcw_queue #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	input  logic         pop,
	output logic [W-1:0] pop_data,
	output logic         full,
	output logic         empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("queue pop while empty");

endmodule

// ===== hw/rtl/tmcw_front.sv =====
// tmcw_front: accepts requests, tracks the cursor and turns each request
// into one back-end command. Depends on tmcw_pkg.
module tmcw_front import tmcw_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	input  logic [1:0]                              req_type,
	input  logic [7:0]                              char_code,
	input  logic [7:0]                              scroll_lines,
	input  logic [4:0]                              read_row,
	input  logic [6:0]                              read_col,
	input  logic [ATTR_W-1:0]                       attr,
	input  logic                                    q_full,
	input  logic                                    clearing,
	output logic                                    busy,
	output logic                                    push,
	output logic [entry_width(COLUMNS, ROWS)-1:0]   entry
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int SRC_W  = ADDR_W + 1;
	localparam int N_W    = $clog2(ROWS + 1);
	localparam int LIN_W  = ADDR_W + 8;

	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic              sweep;
		logic [ADDR_W-1:0] addr;
		logic [CELL_W-1:0] data;
		logic [SRC_W-1:0]  offset;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
	} entry_t;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W:0]   col_inc;
	logic [ROW_W:0]   row_inc;
	logic [N_W-1:0]   n_lines;
	logic [LIN_W-1:0] cur_lin, rd_lin;
	req_type_t        req;
	entry_t           ent;

	assign busy  = q_full | clearing;
	assign push  = start & ~busy;
	assign req   = req_type_t'(req_type);
	assign entry = ent;

	// linear cell addresses for the cursor and for a read
	assign cur_lin = LIN_W'(row_q) * LIN_W'(COLUMNS) + LIN_W'(col_q);
	assign rd_lin  = LIN_W'(read_row) * LIN_W'(COLUMNS) + LIN_W'(read_col);

	// scroll count, anything at or past the row count blanks everything
	assign n_lines = (scroll_lines >= ROWS) ? N_W'(ROWS) : N_W'(scroll_lines);

	// classify the request and work out the cursor after it
	always_comb begin
		ent      = '0;
		ent.col  = col_q;
		ent.row  = row_q;
		ent.data = {attr, SPACE_CODE};
		col_inc  = {1'b0, col_q};
		row_inc  = {1'b0, row_q};
		unique case (req)
			REQ_WRITE: begin
				if (char_code == NEWLINE_CODE) begin
					col_inc = '0;
					row_inc = row_inc + 1'b1;
				end else begin
					ent.wr_en = 1'b1;
					ent.addr  = cur_lin[ADDR_W-1:0];
					ent.data  = {attr, char_code};
					col_inc   = col_inc + 1'b1;
				end
				// wrap at the right edge
				if (col_inc == (COL_W + 1)'(COLUMNS)) begin
					col_inc = '0;
					row_inc = row_inc + 1'b1;
				end
				// past the bottom: scroll one line, stay on the last row
				if (row_inc == (ROW_W + 1)'(ROWS)) begin
					ent.sweep  = 1'b1;
					ent.offset = SRC_W'(COLUMNS);
					row_inc    = (ROW_W + 1)'(ROWS - 1);
				end
				ent.col = col_inc[COL_W-1:0];
				ent.row = row_inc[ROW_W-1:0];
			end
			REQ_CLEAR: begin
				ent.sweep  = 1'b1;
				ent.offset = SRC_W'(CELLS);
			end
			REQ_SCROLL: begin
				if (n_lines != '0) begin
					ent.sweep  = 1'b1;
					ent.offset = SRC_W'(n_lines) * SRC_W'(COLUMNS);
				end
			end
			REQ_READ: begin
				if ((read_row < ROWS) && (read_col < COLUMNS)) begin
					ent.rd_en = 1'b1;
					ent.addr  = rd_lin[ADDR_W-1:0];
				end
			end
		endcase
	end

	// cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			col_q <= ent.col;
			row_q <= ent.row;
		end
	end

endmodule

// ===== hw/rtl/tmcw_back.sv =====
// tmcw_back: executes queued commands on the cell store: single writes and
// reads, and copy/fill sweeps for scroll and clear. Depends on tmcw_pkg, tmcw_ram.
module tmcw_back import tmcw_pkg::*; #(
	parameter int COLUMNS = DEF_COLUMNS,
	parameter int ROWS    = DEF_ROWS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_empty,
	input  logic [entry_width(COLUMNS, ROWS)-1:0] q_entry,
	output logic                                  q_pop,
	output logic                                  clearing,
	output logic                                  done,
	output logic [15:0]                           cell_value,
	output logic [6:0]                            cursor_col,
	output logic [4:0]                            cursor_row
);

	localparam int CELLS  = COLUMNS * ROWS;
	localparam int COL_W  = $clog2(COLUMNS);
	localparam int ROW_W  = $clog2(ROWS);
	localparam int ADDR_W = $clog2(CELLS);
	localparam int SRC_W  = ADDR_W + 1;

	typedef struct packed {
		logic              wr_en;
		logic              rd_en;
		logic              sweep;
		logic [ADDR_W-1:0] addr;
		logic [CELL_W-1:0] data;
		logic [SRC_W-1:0]  offset;
		logic [COL_W-1:0]  col;
		logic [ROW_W-1:0]  row;
	} entry_t;

	entry_t            ent;
	back_state_t       state_q, state_d;
	logic              init_q;
	logic [ADDR_W-1:0] dst_q;
	logic [SRC_W-1:0]  src_q;
	logic [CELL_W-1:0] blank_q;
	logic [COL_W-1:0]  hold_col_q;
	logic [ROW_W-1:0]  hold_row_q;
	logic              wr_s1, copy_s1;
	logic [ADDR_W-1:0] dst_s1;
	logic              rsp_valid_s1, rsp_read_s1;
	logic [COL_W-1:0]  rsp_col_s1;
	logic [ROW_W-1:0]  rsp_row_s1;
	logic              copy_now, last, start_sweep;
	logic              ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [CELL_W-1:0] ram_wdata, ram_rdata;
	logic [COL_W+6:0]  col_ext;
	logic [ROW_W+4:0]  row_ext;

	assign ent         = entry_t'(q_entry);
	assign copy_now    = (src_q < SRC_W'(CELLS));
	assign last        = (dst_q == ADDR_W'(CELLS - 1));
	assign start_sweep = q_pop & ent.sweep;
	assign clearing    = init_q;

	// cell store
	tmcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// next state and store port control
	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		ram_we    = wr_s1;
		ram_waddr = dst_s1;
		ram_wdata = copy_s1 ? ram_rdata : blank_q;
		ram_re    = 1'b0;
		ram_raddr = src_q[ADDR_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				if (!q_empty) begin
					q_pop     = 1'b1;
					ram_we    = ent.wr_en;
					ram_waddr = ent.addr;
					ram_wdata = ent.data;
					ram_re    = ent.rd_en;
					ram_raddr = ent.addr;
					if (ent.sweep) begin
						state_d = ST_SWEEP;
					end
				end
			end
			ST_SWEEP: begin
				ram_re = copy_now;
				if (last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and sweep control; reset starts the zero-fill pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			init_q       <= 1'b1;
			dst_q        <= '0;
			src_q        <= SRC_W'(CELLS);
			blank_q      <= '0;
			wr_s1        <= 1'b0;
			rsp_valid_s1 <= 1'b0;
		end else begin
			state_q      <= state_d;
			wr_s1        <= (state_q == ST_SWEEP);
			rsp_valid_s1 <= (q_pop && !ent.sweep) || (state_q == ST_DRAIN && !init_q);
			if (state_q == ST_DRAIN) begin
				init_q <= 1'b0;
			end
			if (start_sweep) begin
				dst_q   <= '0;
				src_q   <= ent.offset;
				blank_q <= {ent.data[CELL_W-1:CHAR_W], SPACE_CODE};
			end else if (state_q == ST_SWEEP) begin
				dst_q <= dst_q + 1'b1;
				src_q <= src_q + 1'b1;
			end
		end
	end

	// write pipeline and result payload
	always_ff @(posedge clk) begin
		dst_s1  <= dst_q;
		copy_s1 <= copy_now;
		if (start_sweep) begin
			hold_col_q <= ent.col;
			hold_row_q <= ent.row;
		end
		if (q_pop && !ent.sweep) begin
			rsp_col_s1  <= ent.col;
			rsp_row_s1  <= ent.row;
			rsp_read_s1 <= ent.rd_en;
		end else if (state_q == ST_DRAIN) begin
			rsp_col_s1  <= hold_col_q;
			rsp_row_s1  <= hold_row_q;
			rsp_read_s1 <= 1'b0;
		end
	end

	// result ports, cursor masked to the port widths
	assign col_ext    = {7'b0, rsp_col_s1};
	assign row_ext    = {5'b0, rsp_row_s1};
	assign done       = rsp_valid_s1;
	assign cell_value = rsp_read_s1 ? ram_rdata : '0;
	assign cursor_col = col_ext[6:0];
	assign cursor_row = row_ext[4:0];

	a_rsp_not_mid_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_s1 |-> !wr_s1) else $error("result issued while sweep writes pending");

	a_sweep_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |=> wr_s1) else $error("sweep step lost its write");

	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |=> (state_q == ST_IDLE && !init_q))
		else $error("drain did not return to idle");

	a_init_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		init_q |-> !rsp_valid_s1) else $error("result during reset clearing pass");

endmodule

// ===== hw/rtl/text_mode_console_writer.sv =====
// text_mode_console_writer: top level of the text-mode console writer.
// Depends on tmcw_pkg, tmcw_front, tmcw_queue, tmcw_back (and tmcw_ram below it).
//
//  channel   | ports                                             | transfer
//  ----------+---------------------------------------------------+---------------------------
//  request   | start, busy, req_type, char_code, scroll_lines,   | start & !busy at clk edge
//            | read_row, read_col                                |
//  result    | done, cell_value, cursor_col, cursor_row          | done high for one cycle
//  config    | psel, penable, pwrite, paddr, pwdata, prdata,     | APB read or write, pready tied high
//            | pready                                            |
//
// A taken request waits in the command queue until the idle back end pops it; its
// result is then registered. Writes, reads and no-op requests need no sweep, so a
// character stream runs at one byte per cycle while no sweep is running. A clear, a
// nonzero scroll and a line feed or wrap off the bottom row sweep every cell of the store
// through its single write port. After reset a zero-fill pass holds busy high;
// configuration writes are taken during it. A command queue of QUEUE_DEPTH entries (four
// by default) lets requests keep arriving while a sweep runs; busy rises when it fills.
module text_mode_console_writer import tmcw_pkg::*; #(
	parameter int COLUMNS     = DEF_COLUMNS,
	parameter int ROWS        = DEF_ROWS,
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [7:0]  char_code,
	input  logic [7:0]  scroll_lines,
	input  logic [4:0]  read_row,
	input  logic [6:0]  read_col,
	output logic        done,
	output logic [15:0] cell_value,
	output logic [6:0]  cursor_col,
	output logic [4:0]  cursor_row,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int ENTRY_W = entry_width(COLUMNS, ROWS);

	logic [COLOR_W-1:0] fg_q, bg_q;
	logic               cfg_wr;
	cfg_reg_t           cfg_sel;
	logic               push, pop, q_full, q_empty, clearing;
	logic [ENTRY_W-1:0] push_data, pop_data;

	// configuration registers
	assign pready  = 1'b1;
	assign cfg_sel = cfg_reg_t'(paddr[2]);
	assign cfg_wr  = psel & penable & pwrite;
	assign prdata  = (cfg_sel == REG_BG) ? {28'b0, bg_q} : {28'b0, fg_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= FG_RESET;
			bg_q <= BG_RESET;
		end else if (cfg_wr) begin
			if (cfg_sel == REG_FG) begin
				fg_q <= pwdata[COLOR_W-1:0];
			end else begin
				bg_q <= pwdata[COLOR_W-1:0];
			end
		end
	end

	// request decode and cursor
	tmcw_front #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.req_type     (req_type),
		.char_code    (char_code),
		.scroll_lines (scroll_lines),
		.read_row     (read_row),
		.read_col     (read_col),
		.attr         ({bg_q, fg_q}),
		.q_full       (q_full),
		.clearing     (clearing),
		.busy         (busy),
		.push         (push),
		.entry        (push_data)
	);

	// command queue
	tmcw_queue #(
		.W     (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.full      (q_full),
		.empty     (q_empty)
	);

	// cell store execution and results
	tmcw_back #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (q_empty),
		.q_entry    (pop_data),
		.q_pop      (pop),
		.clearing   (clearing),
		.done       (done),
		.cell_value (cell_value),
		.cursor_col (cursor_col),
		.cursor_row (cursor_row)
	);

endmodule

// ===== tb/sv/tb.sv =====
// tb: self-checking testbench for text_mode_console_writer, driving requests and
// color register writes and checking every result against a cell-store predictor.
// Depends on tmcw_pkg and the text_mode_console_writer RTL.
`timescale 1ns / 100ps

module tb import tmcw_pkg::*; ();

	localparam int COLUMNS    = DEF_COLUMNS;
	localparam int ROWS       = DEF_ROWS;
	localparam int CELL_COUNT = COLUMNS * ROWS;
	// clear/scroll sweep plus margin; also covers the zero-fill after reset
	localparam int SWEEP_CYCLES = CELL_COUNT + 8;

	typedef struct packed {
		logic [15:0] cell_val;
		logic [6:0]  col;
		logic [4:0]  row;
	} console_result_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  req_type;
	logic [7:0]  char_code;
	logic [7:0]  scroll_lines;
	logic [4:0]  read_row;
	logic [6:0]  read_col;
	logic        done;
	logic [15:0] cell_value;
	logic [6:0]  cursor_col;
	logic [4:0]  cursor_row;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Predicted console state
	logic [15:0]      shadow_cells [0:CELL_COUNT-1];
	int               shadow_col;
	int               shadow_row;
	logic [3:0]       shadow_fg;
	logic [3:0]       shadow_bg;
	console_result_t  pending_results [$];
	int               mismatch_count;
	int               sender_idle_pct;

	text_mode_console_writer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.char_code    (char_code),
		.scroll_lines (scroll_lines),
		.read_row     (read_row),
		.read_col     (read_col),
		.done         (done),
		.cell_value   (cell_value),
		.cursor_col   (cursor_col),
		.cursor_row   (cursor_row),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard limit on run time
	initial begin
		#20ms;
		$display("Simulation FAILED");
		$finish;
	end

	// ---------------------------------------------------------------- predictor

	// Shift rows up; counts of ROWS or more blank the whole screen
	function automatic void scroll_shadow(input int lines);
		logic [15:0] blank;
		int keep;
		blank = {shadow_bg, shadow_fg, SPACE_CODE};
		if (lines == 0)
			return;
		keep = (lines > ROWS) ? 0 : ROWS - lines;
		for (int i = 0; i < CELL_COUNT; i++) begin
			if (i < keep * COLUMNS)
				shadow_cells[i] = shadow_cells[i + lines * COLUMNS];
			else
				shadow_cells[i] = blank;
		end
	endfunction

	function automatic void write_shadow(input logic [7:0] ch);
		if (ch == NEWLINE_CODE) begin
			shadow_col = 0;
			shadow_row++;
		end else begin
			shadow_cells[shadow_row * COLUMNS + shadow_col] = {shadow_bg, shadow_fg, ch};
			shadow_col++;
		end
		if (shadow_col >= COLUMNS) begin
			shadow_col = 0;
			shadow_row++;
		end
		// line feed or wrap off the bottom row
		if (shadow_row >= ROWS) begin
			scroll_shadow(1);
			shadow_row = ROWS - 1;
		end
	endfunction

	function automatic console_result_t apply_request(input req_type_t kind,
			input logic [7:0] ch, input logic [7:0] lines,
			input logic [4:0] rrow, input logic [6:0] rcol);
		console_result_t res;
		res.cell_val = '0;
		case (kind)
			REQ_WRITE:  write_shadow(ch);
			REQ_CLEAR:  scroll_shadow(ROWS + 1);
			REQ_SCROLL: scroll_shadow(int'(lines));
			default: begin
				if (int'(rrow) < ROWS && int'(rcol) < COLUMNS)
					res.cell_val = shadow_cells[int'(rrow) * COLUMNS + int'(rcol)];
			end
		endcase
		res.col = shadow_col[6:0];
		res.row = shadow_row[4:0];
		return res;
	endfunction

	// ---------------------------------------------------------------- result check

	always @(posedge clk) begin : result_check
		console_result_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: cell_value %h cursor_col %0d cursor_row %0d",
					cell_value, cursor_col, cursor_row);
				mismatch_count++;
			end else begin
				want = pending_results.pop_front();
				if (cell_value !== want.cell_val) begin
					$error("cell_value: expected %h, actual %h", want.cell_val, cell_value);
					mismatch_count++;
				end
				if (cursor_col !== want.col) begin
					$error("cursor_col: expected %0d, actual %0d", want.col, cursor_col);
					mismatch_count++;
				end
				if (cursor_row !== want.row) begin
					$error("cursor_row: expected %0d, actual %0d", want.row, cursor_row);
					mismatch_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- drivers

	// One request transaction; leaves start high unless the sender idles
	task automatic send_req(input req_type_t kind, input logic [7:0] ch,
			input logic [7:0] lines, input logic [4:0] rrow, input logic [6:0] rcol);
		start        <= 1'b1;
		req_type     <= kind;
		char_code    <= ch;
		scroll_lines <= lines;
		read_row     <= rrow;
		read_col     <= rcol;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		pending_results.push_back(apply_request(kind, ch, lines, rrow, rcol));
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < sender_idle_pct);
		end
	endtask

	task automatic send_write(input logic [7:0] ch);
		send_req(REQ_WRITE, ch, 8'd0, 5'd0, 7'd0);
	endtask

	task automatic send_read(input int row, input int col);
		send_req(REQ_READ, 8'd0, 8'd0, row[4:0], col[6:0]);
	endtask

	// Drain all results, then let any sweep still running finish
	task automatic wait_console_idle();
		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SWEEP_CYCLES) @(posedge clk);
	endtask

	task automatic check_color_reg(input cfg_reg_t which, input logic [3:0] want);
		psel    <= 1'b1;
		pwrite  <= 1'b0;
		penable <= 1'b0;
		paddr   <= {which, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[3:0] !== want) begin
			$error("prdata: expected %h, actual %h", want, prdata[3:0]);
			mismatch_count++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// APB write with read-back; only called while the console is idle
	task automatic write_color_reg(input cfg_reg_t which, input logic [3:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {which, 2'b00};
		pwdata  <= {$urandom_range(0, 1) ? 28'hfff_ffff : 28'h0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (which == REG_FG)
			shadow_fg = value;
		else
			shadow_bg = value;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		check_color_reg(which, value);
	endtask

	task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg);
		wait_console_idle();
		write_color_reg(REG_FG, fg);
		write_color_reg(REG_BG, bg);
	endtask

	// ---------------------------------------------------------------- tests

	task automatic test_reset_state();
		check_color_reg(REG_FG, FG_RESET);
		check_color_reg(REG_BG, BG_RESET);
		send_read(0, 0);
		send_read(ROWS - 1, COLUMNS - 1);
	endtask

	task automatic test_out_of_range_reads();
		send_read(ROWS, 0);
		send_read(0, COLUMNS);
		send_read(31, 127);
	endtask

	task automatic test_write_extremes();
		send_write(8'h00);
		send_write(8'hff);
		send_write(8'h41);
		send_write(SPACE_CODE);
		send_write(NEWLINE_CODE);
		send_read(0, 0);
		send_read(0, 1);
		send_read(0, 3);
		send_read(1, 0);
	endtask

	task automatic test_colors();
		set_colors(4'h0, 4'hf);
		send_write(8'h7e);
		send_read(1, 0);
	endtask

	// Clear keeps the cursor; scroll by zero, one, exactly ROWS and beyond
	task automatic test_clear_and_scroll();
		send_req(REQ_CLEAR, 8'd0, 8'd0, 5'd0, 7'd0);
		send_read(0, 0);
		send_write(8'h33);
		send_req(REQ_SCROLL, 8'd0, 8'd0, 5'd0, 7'd0);
		send_req(REQ_SCROLL, 8'd0, 8'd1, 5'd0, 7'd0);
		send_read(0, 1);
		send_req(REQ_SCROLL, 8'd0, 8'(ROWS), 5'd0, 7'd0);
		send_req(REQ_SCROLL, 8'd0, 8'(ROWS + 1), 5'd0, 7'd0);
		send_req(REQ_SCROLL, 8'd0, 8'hff, 5'd0, 7'd0);
	endtask

	// Fill to the bottom row, then wrap past the last column so the screen scrolls
	task automatic test_text_to_bottom();
		set_colors(4'hf, 4'hf);
		while (shadow_row < ROWS - 1)
			send_write(NEWLINE_CODE);
		for (int i = 0; i < COLUMNS + 6; i++)
			send_write(8'($urandom_range(33, 126)));
		send_write(NEWLINE_CODE);
		send_read(ROWS - 3, COLUMNS - 1);
		send_read(ROWS - 2, 0);
		send_read(ROWS - 1, 0);
	endtask

	task automatic test_random_traffic(input int idle_pct, input int item_count);
		int sent;
		int pick;
		int len;
		logic [7:0] lines;
		sender_idle_pct = idle_pct;
		sent = 0;
		while (sent < item_count) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				// a line of text ending in a newline
				len = $urandom_range(1, COLUMNS + 10);
				for (int i = 0; i < len; i++)
					send_write(8'($urandom_range(32, 126)));
				send_write(NEWLINE_CODE);
				sent += len + 1;
			end else if (pick < 50) begin
				send_req(REQ_WRITE,
					($urandom_range(99) < 12) ? NEWLINE_CODE : 8'($urandom),
					8'($urandom), 5'($urandom), 7'($urandom));
				sent++;
			end else if (pick < 75) begin
				if ($urandom_range(99) < 80)
					send_req(REQ_READ, 8'($urandom), 8'($urandom),
						5'($urandom_range(0, ROWS - 1)),
						7'($urandom_range(0, COLUMNS - 1)));
				else
					send_req(REQ_READ, 8'($urandom), 8'($urandom),
						5'($urandom), 7'($urandom));
				sent++;
			end else if (pick < 82) begin
				send_req(REQ_CLEAR, 8'($urandom), 8'($urandom), 5'($urandom),
					7'($urandom));
				sent++;
			end else begin
				case ($urandom_range(3))
					0:       lines = 8'($urandom_range(1, 3));
					1:       lines = 8'd0;
					2:       lines = 8'($urandom_range(ROWS - 1, ROWS + 1));
					default: lines = 8'($urandom);
				endcase
				send_req(REQ_SCROLL, 8'($urandom), lines, 5'($urandom), 7'($urandom));
				sent++;
			end
		end
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		req_type        = REQ_WRITE;
		char_code       = '0;
		scroll_lines    = '0;
		read_row        = '0;
		read_col        = '0;
		psel            = 1'b0;
		penable         = 1'b0;
		pwrite          = 1'b0;
		paddr           = '0;
		pwdata          = '0;
		mismatch_count  = 0;
		sender_idle_pct = 0;
		shadow_col      = 0;
		shadow_row      = 0;
		shadow_fg       = FG_RESET;
		shadow_bg       = BG_RESET;
		for (int i = 0; i < CELL_COUNT; i++)
			shadow_cells[i] = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_out_of_range_reads();
		test_write_extremes();
		test_colors();
		test_clear_and_scroll();
		test_text_to_bottom();

		set_colors(4'h0, 4'h0);
		test_random_traffic(0, 90);
		set_colors(4'($urandom), 4'($urandom));
		test_random_traffic(62, 90);
		set_colors(4'hf, 4'h0);
		test_random_traffic(19, 90);

		wait_console_idle();
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/tmcw_pkg.sv
hw/rtl/tmcw_ram.sv
hw/rtl/tmcw_queue.sv
hw/rtl/tmcw_front.sv
hw/rtl/tmcw_back.sv
hw/rtl/text_mode_console_writer.sv
tb/sv/tb.sv
